// ===== rtl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths and face normal codes of the ray box slab intersect block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int CoordWidthDefault = 32;
   localparam int FracBitsDefault   = 16;
   localparam int NormalWidth       = 3;

   typedef enum logic [NormalWidth-1:0] {
      NORMAL_NONE = 3'd0,
      NORMAL_POSX = 3'd1,
      NORMAL_NEGX = 3'd2,
      NORMAL_POSY = 3'd3,
      NORMAL_NEGY = 3'd4
   } normal_type;

endpackage

// ===== rtl/rbsi_if.sv =====
// ----------------------------------------------------------------------------
// rbsi_req_if / rbsi_rsp_if
// Valid/ready channels carrying one ray box request and one result.
// ----------------------------------------------------------------------------
interface rbsi_req_if
   import rbsi_pkg::*;
#(parameter int COORD_WIDTH = CoordWidthDefault) (input logic clock);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] ray_origin_x;
   logic signed [COORD_WIDTH-1:0] ray_origin_y;
   logic signed [COORD_WIDTH-1:0] ray_dir_x;
   logic signed [COORD_WIDTH-1:0] ray_dir_y;
   logic signed [COORD_WIDTH-1:0] box_center_x;
   logic signed [COORD_WIDTH-1:0] box_center_y;
   logic        [COORD_WIDTH-2:0] box_extent_x;
   logic        [COORD_WIDTH-2:0] box_extent_y;
   modport source (output valid, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
                   box_center_x, box_center_y, box_extent_x, box_extent_y,
                   input ready);
   modport sink (input valid, ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y,
                 box_center_x, box_center_y, box_extent_x, box_extent_y,
                 output ready);
endinterface

interface rbsi_rsp_if
   import rbsi_pkg::*;
#(parameter int COORD_WIDTH = CoordWidthDefault) (input logic clock);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [COORD_WIDTH-1:0] hit_x;
   logic signed [COORD_WIDTH-1:0] hit_y;
   logic        [COORD_WIDTH-1:0] hit_distance;
   logic        [NormalWidth-1:0] face_normal;
   modport source (output valid, hit, hit_x, hit_y, hit_distance, face_normal,
                   input ready);
   modport sink (input valid, hit, hit_x, hit_y, hit_distance, face_normal,
                 output ready);
endinterface

// ===== rtl/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// 2D ray against axis aligned box slab test in signed fixed point.
// pipeline: the W+F+2 restoring divider rows and the W square root rows, one row
// per stage, plus seven single stages
// throughput: one transfer per cycle; a stall freezes the whole pipeline
// reset: synchronous, clears all stage valid bits; payload is not reset
// ----------------------------------------------------------------------------
module ray_box_slab_intersect
   import rbsi_pkg::*;
#(
   parameter int COORD_WIDTH = CoordWidthDefault,
   parameter int FRAC_BITS   = FracBitsDefault
) (
   input logic    clock,
   input logic    reset,
   rbsi_req_if.sink   req,
   rbsi_rsp_if.source rsp
);
   localparam int W   = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int NW  = W + 2;          // numerator magnitude width
   localparam int QW  = NW + F;         // quotient bits of (num << F) / den
   localparam int DS  = QW;             // divider stages
   localparam int RS  = W;              // sqrt stages
   localparam int PW  = 2 * W;
   localparam int LAT = DS + RS + 6;

   localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [QW-1:0]       QLIM = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

   // global pipeline enable
   logic advance_en;
   logic out_valid_ff;
   assign advance_en = !out_valid_ff || rsp.ready;
   assign req.ready  = advance_en;

   // ---------------- stage A: slab edges and numerators
   typedef struct packed {
      logic signed [W-1:0] ox, oy, dx, dy;
      logic signed [W+1:0] nlx, nhx, nly, nhy;
      logic                inx, iny;
   } sa_type;
   sa_type sa_ff;

   always_ff @(posedge clock) begin
      if (advance_en) begin
         logic signed [W+1:0] lx, hx, ly, hy, hhx, hhy;
         hhx = $signed({5'b00000, req.box_extent_x[W-2:2]});
         hhy = $signed({5'b00000, req.box_extent_y[W-2:2]});
         lx = $signed({{2{req.box_center_x[W-1]}}, req.box_center_x}) - hhx;
         hx = $signed({{2{req.box_center_x[W-1]}}, req.box_center_x}) + hhx;
         ly = $signed({{2{req.box_center_y[W-1]}}, req.box_center_y}) - hhy;
         hy = $signed({{2{req.box_center_y[W-1]}}, req.box_center_y}) + hhy;
         sa_ff.ox  <= req.ray_origin_x;
         sa_ff.oy  <= req.ray_origin_y;
         sa_ff.dx  <= req.ray_dir_x;
         sa_ff.dy  <= req.ray_dir_y;
         sa_ff.nlx <= lx - {{2{req.ray_origin_x[W-1]}}, req.ray_origin_x};
         sa_ff.nhx <= hx - {{2{req.ray_origin_x[W-1]}}, req.ray_origin_x};
         sa_ff.nly <= ly - {{2{req.ray_origin_y[W-1]}}, req.ray_origin_y};
         sa_ff.nhy <= hy - {{2{req.ray_origin_y[W-1]}}, req.ray_origin_y};
         sa_ff.inx <= (lx <= $signed({{2{req.ray_origin_x[W-1]}}, req.ray_origin_x}))
                   && ($signed({{2{req.ray_origin_x[W-1]}}, req.ray_origin_x}) <= hx);
         sa_ff.iny <= (ly <= $signed({{2{req.ray_origin_y[W-1]}}, req.ray_origin_y}))
                   && ($signed({{2{req.ray_origin_y[W-1]}}, req.ray_origin_y}) <= hy);
      end
   end

   // ---------------- divider: four lanes, one quotient bit per stage
   typedef struct packed {
      logic [NW-1:0] r;     // partial remainder
      logic [QW-1:0] q;     // quotient bits and pending numerator bits
      logic [W-1:0]  d;     // divisor magnitude
      logic          neg;
   } lane_type;

   typedef struct packed {
      logic signed [W-1:0] ox, oy, dx, dy;
      logic                inx, iny;
   } side_type;

   lane_type dv_ff [DS+1][4];
   side_type ds_ff [DS+1];

   function automatic logic [W-1:0] magw(input logic signed [W-1:0] v);
      magw = v[W-1] ? W'(-v) : v;
   endfunction

   // numerator magnitude followed by F zero bits, all fed msb first
   function automatic lane_type lane_init(input logic signed [W+1:0] num,
                                          input logic signed [W-1:0] den);
      lane_type       l;
      logic [NW-1:0]  n;
      n = num[W+1] ? NW'(-num) : NW'(num);
      l.r   = '0;
      l.q   = {n, {F{1'b0}}};
      l.d   = magw(den);
      l.neg = num[W+1] ^ den[W-1];
      lane_init = l;
   endfunction

   function automatic lane_type lane_step(input lane_type l);
      lane_type       o;
      logic [NW:0]    t;
      o = l;
      t = {l.r, l.q[QW-1]};
      if (t >= {1'b0, {(NW-W){1'b0}}, l.d}) begin
         t = t - {1'b0, {(NW-W){1'b0}}, l.d};
         o.q = {l.q[QW-2:0], 1'b1};
      end else begin
         o.q = {l.q[QW-2:0], 1'b0};
      end
      o.r = t[NW-1:0];
      lane_step = o;
   endfunction

   always_ff @(posedge clock) begin
      if (advance_en) begin
         dv_ff[0][0] <= lane_init(sa_ff.nlx, sa_ff.dx);
         dv_ff[0][1] <= lane_init(sa_ff.nhx, sa_ff.dx);
         dv_ff[0][2] <= lane_init(sa_ff.nly, sa_ff.dy);
         dv_ff[0][3] <= lane_init(sa_ff.nhy, sa_ff.dy);
         ds_ff[0]    <= '{ox: sa_ff.ox, oy: sa_ff.oy, dx: sa_ff.dx, dy: sa_ff.dy,
                          inx: sa_ff.inx, iny: sa_ff.iny};
         for (int s = 0; s < DS; s++) begin
            for (int k = 0; k < 4; k++)
               dv_ff[s+1][k] <= lane_step(dv_ff[s][k]);
            ds_ff[s+1] <= ds_ff[s];
         end
      end
   end

   // ---------------- stage T: saturate, order, combine
   function automatic logic signed [W-1:0] qsat(input lane_type l);
      if (l.q >= QLIM)
         qsat = l.neg ? CMIN : CMAX;
      else if (l.neg)
         qsat = W'(-l.q);
      else
         qsat = W'(l.q);
   endfunction

   typedef struct packed {
      logic signed [W-1:0] ox, oy, dx, dy, tn;
      logic                ok;
      normal_type          nrm;
   } st_type;
   st_type st_ff;

   always_ff @(posedge clock) begin
      if (advance_en) begin
         logic signed [W-1:0] a, b, c, e, nx, fx, ny, fy;
         side_type sd;
         sd = ds_ff[DS];
         a = qsat(dv_ff[DS][0]);
         b = qsat(dv_ff[DS][1]);
         c = qsat(dv_ff[DS][2]);
         e = qsat(dv_ff[DS][3]);
         if (sd.dx == '0) begin
            nx = CMIN; fx = CMAX;
         end else begin
            nx = (a < b) ? a : b; fx = (a < b) ? b : a;
         end
         if (sd.dy == '0) begin
            ny = CMIN; fy = CMAX;
         end else begin
            ny = (c < e) ? c : e; fy = (c < e) ? e : c;
         end
         st_ff.ox <= sd.ox;
         st_ff.oy <= sd.oy;
         st_ff.dx <= sd.dx;
         st_ff.dy <= sd.dy;
         st_ff.tn <= (nx > ny) ? nx : ny;
         st_ff.ok <= !((sd.dx == '0) && !sd.inx) && !((sd.dy == '0) && !sd.iny)
                  && !(nx > fy) && !(ny > fx)
                  && !(((fx < fy) ? fx : fy) < 0);
         if (nx > ny)
            st_ff.nrm <= sd.dx[W-1] ? NORMAL_POSX : NORMAL_NEGX;
         else if (nx < ny)
            st_ff.nrm <= sd.dy[W-1] ? NORMAL_POSY : NORMAL_NEGY;
         else
            st_ff.nrm <= NORMAL_NONE;
      end
   end

   // ---------------- stage M: t * dir products
   typedef struct packed {
      logic signed [W-1:0] ox, oy;
      logic [PW-1:0]       px, py;
      logic                sx, sy, ok;
      normal_type          nrm;
   } sm_type;
   sm_type sm_ff;

   always_ff @(posedge clock) begin
      if (advance_en) begin
         sm_ff.ox  <= st_ff.ox;
         sm_ff.oy  <= st_ff.oy;
         sm_ff.px  <= {{W{1'b0}}, magw(st_ff.tn)} * {{W{1'b0}}, magw(st_ff.dx)};
         sm_ff.py  <= {{W{1'b0}}, magw(st_ff.tn)} * {{W{1'b0}}, magw(st_ff.dy)};
         sm_ff.sx  <= st_ff.tn[W-1] ^ st_ff.dx[W-1];
         sm_ff.sy  <= st_ff.tn[W-1] ^ st_ff.dy[W-1];
         sm_ff.ok  <= st_ff.ok;
         sm_ff.nrm <= st_ff.nrm;
      end
   end

   // ---------------- stage P: hit point, delta
   typedef struct packed {
      logic signed [W-1:0] hx, hy;
      logic [W:0]          mx, my;
      logic                ok;
      normal_type          nrm;
   } sp_type;
   sp_type sp_ff;

   function automatic logic signed [W-1:0] addsat(input logic signed [W-1:0] o,
                                                 input logic [PW-1:0] p,
                                                 input logic sgn);
      logic [PW-1:0]       s;
      logic signed [PW+1:0] v;
      s = p >> F;
      v = sgn ? -$signed({2'b00, s}) : $signed({2'b00, s});
      v = v + $signed({{(PW+2-W){o[W-1]}}, o});
      if (v > $signed({{(PW+2-W){1'b0}}, CMAX}))      addsat = CMAX;
      else if (v < $signed({{(PW+2-W){1'b1}}, CMIN})) addsat = CMIN;
      else                                            addsat = W'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (advance_en) begin
         logic signed [W-1:0] hx, hy;
         logic signed [W:0]   ex, ey;
         hx = addsat(sm_ff.ox, sm_ff.px, sm_ff.sx);
         hy = addsat(sm_ff.oy, sm_ff.py, sm_ff.sy);
         ex = $signed({hx[W-1], hx}) - $signed({sm_ff.ox[W-1], sm_ff.ox});
         ey = $signed({hy[W-1], hy}) - $signed({sm_ff.oy[W-1], sm_ff.oy});
         sp_ff.hx  <= hx;
         sp_ff.hy  <= hy;
         sp_ff.mx  <= ex[W] ? (W+1)'(-ex) : (W+1)'(ex);
         sp_ff.my  <= ey[W] ? (W+1)'(-ey) : (W+1)'(ey);
         sp_ff.ok  <= sm_ff.ok;
         sp_ff.nrm <= sm_ff.nrm;
      end
   end

   // ---------------- stage S: sum of squares, then square root rows
   typedef struct packed {
      logic signed [W-1:0] hx, hy;
      logic [PW+2:0]       sum;
      logic [W-1:0]        res;
      logic                sat, ok;
      normal_type          nrm;
   } sq_type;
   sq_type sq_ff [RS+1];

   always_ff @(posedge clock) begin
      if (advance_en) begin
         logic [PW+2:0] s;
         s = (PW+3)'(sp_ff.mx) * (PW+3)'(sp_ff.mx)
           + (PW+3)'(sp_ff.my) * (PW+3)'(sp_ff.my);
         sq_ff[0].hx  <= sp_ff.hx;
         sq_ff[0].hy  <= sp_ff.hy;
         sq_ff[0].sum <= s;
         sq_ff[0].res <= '0;
         sq_ff[0].sat <= s[PW+2:PW] != '0;
         sq_ff[0].ok  <= sp_ff.ok;
         sq_ff[0].nrm <= sp_ff.nrm;
         // one result bit per stage, msb first
         for (int s2 = 0; s2 < RS; s2++) begin
            sq_type       row;
            logic [W-1:0] cnd;
            row = sq_ff[s2];
            cnd = sq_ff[s2].res | (W'(1) << (RS - 1 - s2));
            if ((PW+3)'({{W{1'b0}}, cnd} * {{W{1'b0}}, cnd}) <= sq_ff[s2].sum)
               row.res = cnd;
            sq_ff[s2+1] <= row;
         end
      end
   end

   // ---------------- output register
   logic                out_hit_ff;
   logic signed [W-1:0] out_x_ff, out_y_ff;
   logic [W-1:0]        out_d_ff;
   normal_type          out_n_ff;

   always_ff @(posedge clock) begin
      if (advance_en) begin
         sq_type f;
         f = sq_ff[RS];
         out_hit_ff <= f.ok;
         out_x_ff   <= f.ok ? f.hx : '0;
         out_y_ff   <= f.ok ? f.hy : '0;
         out_d_ff   <= !f.ok ? '0 : (f.sat ? '1 : f.res);
         out_n_ff   <= f.ok ? f.nrm : NORMAL_NONE;
      end
   end

   // valid bits travel in a shift line alongside the stages
   logic [LAT-1:0] vl_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance_en) begin
         vl_ff        <= {vl_ff[LAT-2:0], req.valid};
         out_valid_ff <= vl_ff[LAT-1];
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.hit          = out_hit_ff;
   assign rsp.hit_x        = out_x_ff;
   assign rsp.hit_y        = out_y_ff;
   assign rsp.hit_distance = out_d_ff;
   assign rsp.face_normal  = out_n_ff;

endmodule

// ===== tb/sv/ray_box_slab_intersect_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_tb
// Streams directed and random ray/box pairs through the slab intersect block
// under random idling on both channels, predicts every result with a fixed
// point slab test of its own and compares each result field by field.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_tb
   import rbsi_pkg::*;
();

   localparam int  Q       = 65536;
   localparam int  LATENCY = 2 * CoordWidthDefault + FracBitsDefault + 9;
   localparam longint CMAX = 64'sd2147483647;
   localparam longint CMIN = -64'sd2147483648;

   typedef struct {
      logic signed [31:0] ox, oy, dx, dy, cx, cy;
      logic        [30:0] ex, ey;
   } ray_box_type;

   typedef struct {
      logic               hit;
      logic signed [31:0] px, py;
      logic        [31:0] distance;
      normal_type         normal;
   } hit_info_type;

   class hit_scoreboard;
      hit_info_type pending_hits[$];
      int           errors;

      function longint fixed_div(longint num, longint den);
         logic [63:0] n, d, q;
         logic        neg;
         n   = num < 0 ? -num : num;
         d   = den < 0 ? -den : den;
         neg = (num < 0) != (den < 0);
         q   = (n << 16) / d;
         if (neg) return q >= 64'h8000_0000 ? CMIN : -longint'(q);
         return q > 64'h7fff_ffff ? CMAX : longint'(q);
      endfunction

      function longint step_along(longint o, longint t, longint d);
         logic [127:0] p;
         logic [63:0]  s;
         longint       v, r;
         p = 128'(t < 0 ? -t : t) * 128'(d < 0 ? -d : d);
         s = p[79:16];
         if (p[127:80] != 0 || s > 64'h4000_0000_0000_0000) s = 64'h4000_0000_0000_0000;
         v = ((t < 0) != (d < 0)) ? -longint'(s) : longint'(s);
         r = o + v;
         return r > CMAX ? CMAX : (r < CMIN ? CMIN : r);
      endfunction

      function logic [31:0] euclid(longint ax, longint ay);
         logic [127:0] s, c;
         logic [31:0]  res;
         s = 128'(ax < 0 ? -ax : ax) * 128'(ax < 0 ? -ax : ax)
           + 128'(ay < 0 ? -ay : ay) * 128'(ay < 0 ? -ay : ay);
         if (s >= (128'd1 << 64)) return 32'hffff_ffff;
         res = 0;
         for (int b = 31; b >= 0; b--) begin
            c = 128'(res | (32'd1 << b));
            if (c * c <= s) res = res | (32'd1 << b);
         end
         return res;
      endfunction

      function logic slab_span(longint o, longint d, longint c, longint h,
                               output longint nr, output longint fr);
         longint a, b;
         if (d == 0) begin
            nr = CMIN;
            fr = CMAX;
            return (c - h <= o) && (o <= c + h);
         end
         a  = fixed_div(c - h - o, d);
         b  = fixed_div(c + h - o, d);
         nr = a < b ? a : b;
         fr = a < b ? b : a;
         return 1;
      endfunction

      function void note_request(ray_box_type r);
         hit_info_type e;
         longint       nx, fx, ny, fy, tn, tf, px, py;
         logic         okx, oky;
         e = '{hit: 0, px: 0, py: 0, distance: 0, normal: NORMAL_NONE};
         okx = slab_span(r.ox, r.dx, r.cx, longint'(r.ex >> 2), nx, fx);
         oky = slab_span(r.oy, r.dy, r.cy, longint'(r.ey >> 2), ny, fy);
         if (okx && oky && !(nx > fy || ny > fx)) begin
            tn = nx > ny ? nx : ny;
            tf = fx < fy ? fx : fy;
            if (tf >= 0) begin
               px = step_along(r.ox, tn, r.dx);
               py = step_along(r.oy, tn, r.dy);
               e.hit      = 1;
               e.px       = px[31:0];
               e.py       = py[31:0];
               e.distance = euclid(px - r.ox, py - r.oy);
               if (nx > ny) e.normal = r.dx < 0 ? NORMAL_POSX : NORMAL_NEGX;
               else if (nx < ny) e.normal = r.dy < 0 ? NORMAL_POSY : NORMAL_NEGY;
            end
         end
         pending_hits.insert(pending_hits.size(), e);
      endfunction

      function void check_result(hit_info_type a);
         hit_info_type e;
         if (pending_hits.size() == 0) begin
            $display("%0t: result transfer with nothing expected", $time);
            errors++;
            return;
         end
         e = pending_hits.pop_front();
         if (a.hit !== e.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, a.hit);
            errors++;
         end
         if (a.px !== e.px) begin
            $display("%0t: hit_x expected %h actual %h", $time, e.px, a.px);
            errors++;
         end
         if (a.py !== e.py) begin
            $display("%0t: hit_y expected %h actual %h", $time, e.py, a.py);
            errors++;
         end
         if (a.distance !== e.distance) begin
            $display("%0t: hit_distance expected %h actual %h", $time, e.distance,
                     a.distance);
            errors++;
         end
         if (a.normal !== e.normal) begin
            $display("%0t: face_normal expected %0d actual %0d", $time, e.normal,
                     a.normal);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   rbsi_req_if req (.clock(clock));
   rbsi_rsp_if rsp (.clock(clock));

   ray_box_slab_intersect DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   hit_scoreboard sb = new();
   int            sent;
   ray_box_type   directed[$];

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20ms);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic ray_box_type make_item(int ox, int oy, int dx, int dy, int cx,
                                             int cy, int ex, int ey);
      ray_box_type r;
      r = '{ox: ox, oy: oy, dx: dx, dy: dy, cx: cx, cy: cy, ex: ex[30:0], ey: ey[30:0]};
      return r;
   endfunction

   function automatic void add_directed(ray_box_type r);
      directed.insert(directed.size(), r);
   endfunction

   function automatic int near_value(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic ray_box_type random_item();
      ray_box_type r;
      int          sel, cx, cy, ox, oy;
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
         r = '{ox: $urandom, oy: $urandom, dx: $urandom, dy: $urandom, cx: $urandom,
               cy: $urandom, ex: 31'($urandom), ey: 31'($urandom)};
      end else begin
         cx = near_value(200 * Q);
         cy = near_value(200 * Q);
         ox = near_value(200 * Q);
         oy = near_value(200 * Q);
         r.cx = cx;
         r.cy = cy;
         r.ox = ox;
         r.oy = oy;
         r.ex = 31'($urandom_range(0, 160 * Q));
         r.ey = 31'($urandom_range(0, 160 * Q));
         r.dx = (cx - ox) / int'($urandom_range(1, 64)) + near_value(4 * Q);
         r.dy = (cy - oy) / int'($urandom_range(1, 64)) + near_value(4 * Q);
         if (sel == 2) r.dx = 0;
         if (sel == 3) r.dy = 0;
         if (sel == 4) r.dx = -r.dx;
      end
      return r;
   endfunction

   task automatic send_request(ray_box_type r);
      req.valid        <= 1;
      req.ray_origin_x <= r.ox;
      req.ray_origin_y <= r.oy;
      req.ray_dir_x    <= r.dx;
      req.ray_dir_y    <= r.dy;
      req.box_center_x <= r.cx;
      req.box_center_y <= r.cy;
      req.box_extent_x <= r.ex;
      req.box_extent_y <= r.ey;
      do @(posedge clock); while (!req.ready);
      sb.note_request(r);
      sent++;
      @(negedge clock);
      if ($urandom_range(0, 1) == 0) begin
         req.valid <= 0;
         repeat (idle_length()) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result('{hit: rsp.hit, px: rsp.hit_x, py: rsp.hit_y,
                           distance: rsp.hit_distance, normal: normal_type'(rsp.face_normal)});
   end

   initial begin
      int  stall;
      int  run;
      logic held;
      rsp.ready = 0;
      stall = 0;
      run   = 0;
      held  = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && sent >= 400) begin
            held = 1;
            stall = 400;
         end
         if (stall > 0) begin
            rsp.ready <= 0;
            stall--;
         end else if (run > 0) begin
            rsp.ready <= 1;
            run--;
         end else begin
            case ($urandom_range(0, 3))
               0: run = $urandom_range(20, 80);
               1: stall = idle_length();
               default: rsp.ready <= 1;
            endcase
         end
         @(negedge clock);
      end
   end

   initial begin
      reset = 1;
      sent  = 0;
      req.valid = 0;
      req.ray_origin_x = 0;
      req.ray_origin_y = 0;
      req.ray_dir_x    = 0;
      req.ray_dir_y    = 0;
      req.box_center_x = 0;
      req.box_center_y = 0;
      req.box_extent_x = 0;
      req.box_extent_y = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // entry from each side
      add_directed(make_item(-10 * Q, 0, Q, 0, 0, 0, 8 * Q, 8 * Q));
      add_directed(make_item(10 * Q, 0, -Q, 0, 0, 0, 8 * Q, 8 * Q));
      add_directed(make_item(0, -10 * Q, 0, Q, 0, 0, 8 * Q, 8 * Q));
      add_directed(make_item(0, 10 * Q, 0, -Q, 0, 0, 8 * Q, 8 * Q));
      // corner hit, entry tie
      add_directed(make_item(-4 * Q, -4 * Q, Q, Q, 0, 0, 8 * Q, 8 * Q));
      // zero direction, inside and outside
      add_directed(make_item(Q, Q, 0, 0, 0, 0, 8 * Q, 8 * Q));
      add_directed(make_item(9 * Q, Q, 0, 0, 0, 0, 8 * Q, 8 * Q));
      add_directed(make_item(2 * Q, -9 * Q, 0, Q, 0, 0, 8 * Q, 8 * Q));
      add_directed(make_item(2 * Q, -9 * Q, 0, Q, 0, 0, 9, 8 * Q));
      // box behind the ray, origin inside, disjoint slabs
      add_directed(make_item(10 * Q, 0, Q, 0, 0, 0, 8 * Q, 8 * Q));
      add_directed(make_item(Q, -Q, 3 * Q, Q, 0, 0, 8 * Q, 8 * Q));
      add_directed(make_item(-10 * Q, -10 * Q, Q, -Q, 0, 0, 8 * Q, 8 * Q));
      // field extremes and saturation
      add_directed(make_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      add_directed(make_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 0, 0));
      add_directed(make_item(32'h80000000, 0, 1, 0, 32'h7fffffff, 0, 7, 8 * Q));
      add_directed(make_item(32'h80000000, 32'h80000000, Q, Q, 32'h60000000,
                             32'h60000000, 32'h7fffffff, 32'h7fffffff));
      add_directed(make_item(0, 0, 1, 32'h80000000, 0, 32'h80000000, 32'h7fffffff,
                             32'h7fffffff));
      add_directed(make_item(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                             0, 0, 32'h7fffffff, 32'h7fffffff));
      add_directed(make_item(-1, 1, -1, 1, 0, 0, 3, 3));

      @(negedge clock);
      foreach (directed[i]) send_request(directed[i]);
      repeat (1850) send_request(random_item());
      req.valid <= 0;

      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rbsi_pkg.sv
rtl/rbsi_if.sv
rtl/ray_box_slab_intersect.sv
tb/sv/ray_box_slab_intersect_tb.sv
